/* hw/rtl/ght_pkg.sv */
// shared types and constants of the generational handle table
package ght_pkg;

  localparam logic [1:0] MODE_INSTALL = 2'd0;
  localparam logic [1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [1:0] MODE_CLOSE   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [15:0] NO_OBJECT = 16'hFFFF;

  // control from the sequencer to the slot store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_active;
  } store_ctl_t;

endpackage

/* hw/rtl/ght_slot_store.sv */
// slot store: entry memory with written bits, and the active flags
module ght_slot_store #(
  parameter int SLOT_COUNT = 32,
  parameter int GEN_BITS   = 27,
  parameter int ADDR_W     = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ght_pkg::store_ctl_t   ctl,
  input  logic [ADDR_W-1:0]     addr,
  input  logic [GEN_BITS-1:0]   wr_gen,
  input  logic                  wr_type,
  input  logic [15:0]           wr_obj,
  input  logic                  wr_side,
  output logic [GEN_BITS-1:0]   rd_gen,
  output logic                  rd_type,
  output logic [15:0]           rd_obj,
  output logic                  rd_side,
  output logic [SLOT_COUNT-1:0] active
);

  localparam int ENTRY_W = GEN_BITS + 18;

  logic [ENTRY_W-1:0]    mem_r [SLOT_COUNT];
  logic [ENTRY_W-1:0]    rd_data_r;
  logic                  rd_written_r;
  logic [SLOT_COUNT-1:0] written_r;
  logic [SLOT_COUNT-1:0] active_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[addr] <= {wr_gen, wr_type, wr_obj, wr_side};
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      active_r     <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        written_r[addr] <= 1'b1;
        active_r[addr]  <= ctl.wr_active;
      end
      if (ctl.rd_en) begin
        rd_written_r <= written_r[addr];
      end
    end
  end

  // a never written entry reads as generation 1, type 0, NO_OBJECT and side 0
  always_comb begin
    if (rd_written_r) begin
      rd_gen  = rd_data_r[ENTRY_W-1 -: GEN_BITS];
      rd_type = rd_data_r[17];
      rd_obj  = rd_data_r[16:1];
      rd_side = rd_data_r[0];
    end else begin
      rd_gen  = GEN_BITS'(1);
      rd_type = 1'b0;
      rd_obj  = ght_pkg::NO_OBJECT;
      rd_side = 1'b0;
    end
  end

  assign active = active_r;

endmodule

/* hw/rtl/generational_handle_table_unit.sv */
// sequence: lookup and close pass through the read, check and finish states from accept to
// result; a malformed handle or the unused mode goes straight to finish; install first
// scans for a free slot, then reads, checks and finishes; a full table finishes from the scan
// one transaction at a time; the next input can be taken once the result sits in the output
// register, also while that result is stalled; a stalled result holds off the next result
// reset clears all active flags and marks every entry unwritten; no clearing pass
module generational_handle_table_unit #(
  parameter int SLOT_COUNT      = 32,
  parameter int SLOT_FIELD_BITS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // handle[31:0], object_type[32], obj_index[48:33], side[49]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // new_handle[31:0], found_index[47:32], found_side[48], found_type[49]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int GEN_BITS = 32 - SLOT_FIELD_BITS;
  localparam int USABLE   = (SLOT_COUNT < (1 << SLOT_FIELD_BITS)) ? SLOT_COUNT
                                                                  : (1 << SLOT_FIELD_BITS);
  localparam int SLOT_AW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SCAN_W   = $clog2(USABLE + 1);
  localparam logic [31:0] SLOT_MASK = (32'd1 << SLOT_FIELD_BITS) - 32'd1;
  localparam logic [GEN_BITS-1:0] GEN_MAX = {GEN_BITS{1'b1}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [GEN_BITS-1:0] hgen_r, hgen_nxt;
  logic [SLOT_AW-1:0]  slot_r, slot_nxt;
  logic [SCAN_W-1:0]   scan_r, scan_nxt;
  logic                otype_r, otype_nxt;
  logic [15:0]         oindex_r, oindex_nxt;
  logic                oside_r, oside_nxt;

  logic [1:0]          res_status_r, res_status_nxt;
  logic [31:0]         res_handle_r, res_handle_nxt;
  logic [15:0]         res_index_r, res_index_nxt;
  logic                res_side_r, res_side_nxt;
  logic                res_type_r, res_type_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [55:0]         out_data_r, out_data_nxt;
  logic [1:0]          out_user_r, out_user_nxt;

  ght_pkg::store_ctl_t ctl;
  logic [GEN_BITS-1:0] wr_gen;
  logic                wr_type;
  logic [15:0]         wr_obj;
  logic                wr_side;
  logic [GEN_BITS-1:0] rd_gen;
  logic                rd_type;
  logic [15:0]         rd_obj;
  logic                rd_side;
  logic [SLOT_COUNT-1:0] active;

  logic [31:0]         hslot_w;
  logic [GEN_BITS-1:0] hgen_w;
  logic                form_ok;
  logic [GEN_BITS-1:0] gen_use;
  logic [GEN_BITS-1:0] gen_adv;
  logic                in_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign hslot_w = in_tdata[31:0] & SLOT_MASK;
  assign hgen_w  = in_tdata[31:SLOT_FIELD_BITS];
  assign form_ok = (hgen_w != '0) && (hslot_w < 32'(USABLE));
  assign gen_use = (rd_gen == '0) ? GEN_BITS'(1) : rd_gen;
  assign gen_adv = ((rd_gen == '0) || (rd_gen == GEN_MAX)) ? GEN_BITS'(1)
                                                           : rd_gen + GEN_BITS'(1);

  ght_slot_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .GEN_BITS   (GEN_BITS),
    .ADDR_W     (SLOT_AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .addr    (slot_r),
    .wr_gen  (wr_gen),
    .wr_type (wr_type),
    .wr_obj  (wr_obj),
    .wr_side (wr_side),
    .rd_gen  (rd_gen),
    .rd_type (rd_type),
    .rd_obj  (rd_obj),
    .rd_side (rd_side),
    .active  (active)
  );

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    hgen_nxt       = hgen_r;
    slot_nxt       = slot_r;
    scan_nxt       = scan_r;
    otype_nxt      = otype_r;
    oindex_nxt     = oindex_r;
    oside_nxt      = oside_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_index_nxt  = res_index_r;
    res_side_nxt   = res_side_r;
    res_type_nxt   = res_type_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    ctl            = '0;
    wr_gen         = gen_use;
    wr_type        = otype_r;
    wr_obj         = oindex_r;
    wr_side        = oside_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt       = in_tuser;
          hgen_nxt       = hgen_w;
          slot_nxt       = hslot_w[SLOT_AW-1:0];
          scan_nxt       = '0;
          otype_nxt      = in_tdata[32];
          oindex_nxt     = in_tdata[48:33];
          oside_nxt      = in_tdata[49];
          res_status_nxt = ght_pkg::ST_INVALID;
          res_handle_nxt = '0;
          res_index_nxt  = '0;
          res_side_nxt   = 1'b0;
          res_type_nxt   = 1'b0;
          if (in_tuser == ght_pkg::MODE_INSTALL) begin
            state_nxt = S_SCAN;
          end else if ((in_tuser == ght_pkg::MODE_LOOKUP ||
                        in_tuser == ght_pkg::MODE_CLOSE) && form_ok) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SCAN: begin
        // one slot flag per cycle, lowest first
        if (scan_r == SCAN_W'(USABLE)) begin
          res_status_nxt = ght_pkg::ST_FULL;
          state_nxt      = S_FIN;
        end else if (!active[SLOT_AW'(scan_r)]) begin
          slot_nxt  = SLOT_AW'(scan_r);
          state_nxt = S_READ;
        end else begin
          scan_nxt = scan_r + SCAN_W'(1);
        end
      end
      S_READ: begin
        ctl.rd_en = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_FIN;
        if (mode_r == ght_pkg::MODE_INSTALL) begin
          ctl.wr_en      = 1'b1;
          ctl.wr_active  = 1'b1;
          res_status_nxt = ght_pkg::ST_OK;
          res_handle_nxt = {gen_use, SLOT_FIELD_BITS'(slot_r)};
        end else if (active[slot_r] && rd_gen == hgen_r &&
                     (mode_r == ght_pkg::MODE_CLOSE || rd_type == otype_r)) begin
          res_status_nxt = ght_pkg::ST_OK;
          res_index_nxt  = rd_obj;
          res_side_nxt   = rd_side;
          res_type_nxt   = rd_type;
          if (mode_r == ght_pkg::MODE_CLOSE) begin
            ctl.wr_en     = 1'b1;
            ctl.wr_active = 1'b0;
            wr_gen        = gen_adv;
            wr_type       = 1'b0;
            wr_obj        = ght_pkg::NO_OBJECT;
            wr_side       = 1'b0;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, res_type_r, res_side_r, res_index_r, res_handle_r};
          out_user_nxt  = res_status_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    hgen_r       <= hgen_nxt;
    slot_r       <= slot_nxt;
    scan_r       <= scan_nxt;
    otype_r      <= otype_nxt;
    oindex_r     <= oindex_nxt;
    oside_r      <= oside_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_index_r  <= res_index_nxt;
    res_side_r   <= res_side_nxt;
    res_type_r   <= res_type_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* hw/rtl/ght_checker.sv */
// port-level checks of the handle table, bound to the top level
module ght_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one transaction at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // failed operations carry all-zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ght_pkg::ST_OK |-> out_tdata == '0)
    else $error("failed result carries data");

  // status codes stay in range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == ght_pkg::ST_OK || out_tuser == ght_pkg::ST_INVALID ||
                   out_tuser == ght_pkg::ST_FULL)
    else $error("status code out of range");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind generational_handle_table_unit ght_checker u_ght_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
